// ----- rtl/isd_pkg.sv -----
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types and constants for the incremental shuffle draw block.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int unsigned CntW = 13;  // song count and draw position
  localparam int unsigned IdxW = 12;  // entry index port
  localparam int unsigned ValW = 32;  // entry value and drawn id ports
  localparam int unsigned RndW = 31;  // random value and divider width

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START1,
    S_DIV1,
    S_START2,
    S_DIV2,
    S_RD_I,
    S_RD_J,
    S_WR_J
  } state_e;

endpackage

// ----- rtl/incremental_shuffle_draw.sv -----
// ----------------------------------------------------------------------------
// incremental_shuffle_draw
// Deals track ids from a table in random order, one incremental Fisher-Yates
// step per draw item. Load items write one table entry.
// ----------------------------------------------------------------------------
// Load: accepted while idle, no result; next item accepted the cycle after.
// Draw: result valid after two divider passes (start, 31 quotient bits,
//   done) and the table access states S_RD_I, S_RD_J and S_WR_J; a stalled
//   result holds the draw in its last state, S_WR_J.
// One item in flight; the next item is accepted the cycle after a draw ends.
// Reset: position 0, song_count 1, no result pending; table undefined.
module incremental_shuffle_draw #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned ID_WIDTH    = 32,
  parameter int unsigned RANDOM_MAX  = 2147483647
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [isd_pkg::IdxW-1:0]  entry_index_i,
  input  logic [isd_pkg::ValW-1:0]  entry_value_i,
  input  logic [isd_pkg::RndW-1:0]  random_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [isd_pkg::ValW-1:0]  drawn_id_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [isd_pkg::CntW-1:0]  cfg_data_i
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = isd_pkg::CntW;
  localparam int unsigned RndW = isd_pkg::RndW;

  isd_pkg::state_e state_q, state_d;

  logic [CntW-1:0]     song_count_q;
  logic [CntW-1:0]     pos_q;
  logic [CntW-1:0]     i_q, n_q, j_q;
  logic [RndW-1:0]     r_q, div_q;
  logic [ID_WIDTH-1:0] val_i_q;
  logic                out_valid_q;
  logic [isd_pkg::ValW-1:0] drawn_id_q;

  logic [CntW-1:0]     n_eff, i_eff, lim;
  logic                in_acc, draw_acc, load_acc, out_free, finish;

  logic                div_start, div_done;
  logic [RndW-1:0]     div_dividend, div_divisor, div_quot;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ID_WIDTH-1:0] ram_wdata, ram_rdata;

  assign in_stall_o  = (state_q != isd_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign draw_acc    = in_acc && (command_i == isd_pkg::CMD_DRAW);
  assign load_acc    = in_acc && (command_i == isd_pkg::CMD_LOAD) &&
                       (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    n_eff = song_count_q;
    if (n_eff == '0) begin
      n_eff = CntW'(1);
    end
    if (32'(n_eff) > 32'(TABLE_DEPTH)) begin
      n_eff = CntW'(TABLE_DEPTH);
    end
    i_eff = (pos_q >= n_eff) ? '0 : pos_q;
  end

  assign lim = n_q - CntW'(1) - i_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isd_pkg::S_IDLE:   if (draw_acc) state_d = isd_pkg::S_START1;
      isd_pkg::S_START1: state_d = isd_pkg::S_DIV1;
      isd_pkg::S_DIV1:   if (div_done) state_d = isd_pkg::S_START2;
      isd_pkg::S_START2: state_d = isd_pkg::S_DIV2;
      isd_pkg::S_DIV2:   if (div_done) state_d = isd_pkg::S_RD_I;
      isd_pkg::S_RD_I:   state_d = isd_pkg::S_RD_J;
      isd_pkg::S_RD_J:   state_d = isd_pkg::S_WR_J;
      isd_pkg::S_WR_J:   if (out_free) state_d = isd_pkg::S_IDLE;
      default:           state_d = isd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    div_start    = 1'b0;
    div_dividend = r_q;
    div_divisor  = div_q;
    ram_we       = 1'b0;
    ram_waddr    = AW'(entry_index_i);
    ram_wdata    = ID_WIDTH'(entry_value_i);
    ram_raddr    = AW'(i_q);
    finish       = 1'b0;
    case (state_q)
      isd_pkg::S_IDLE: begin
        ram_we = load_acc;
      end
      isd_pkg::S_START1: begin
        div_start    = 1'b1;
        div_dividend = RndW'(RANDOM_MAX);
        div_divisor  = RndW'(n_q - i_q);
      end
      isd_pkg::S_START2: begin
        div_start = 1'b1;
      end
      isd_pkg::S_RD_I: begin
        ram_raddr = AW'(i_q);
      end
      isd_pkg::S_RD_J: begin
        ram_raddr = AW'(j_q);
        ram_we    = 1'b1;
        ram_waddr = AW'(i_q);
        ram_wdata = ram_rdata;
      end
      isd_pkg::S_WR_J: begin
        // entry j keeps its old value until the result can leave
        ram_raddr = AW'(j_q);
        ram_we    = out_free;
        ram_waddr = AW'(j_q);
        ram_wdata = val_i_q;
        finish    = out_free;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // The first write in S_RD_J only refreshes entry i with its own value;
  // entry i gets the old entry j when the item finishes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= isd_pkg::S_IDLE;
      song_count_q <= CntW'(1);
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        song_count_q <= cfg_data_i;
      end
      if (finish) begin
        pos_q       <= i_q + CntW'(1);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic fix_i;
  assign fix_i = (state_q == isd_pkg::S_WR_J) && out_free;

  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      i_q <= i_eff;
      n_q <= n_eff;
      r_q <= random_value_i;
    end
    if (state_q == isd_pkg::S_DIV1 && div_done) begin
      div_q <= (div_quot == '0) ? RndW'(1) : div_quot;
    end
    if (state_q == isd_pkg::S_DIV2 && div_done) begin
      if (div_quot > RndW'(lim)) begin
        j_q <= n_q - CntW'(1);
      end else begin
        j_q <= i_q + div_quot[CntW-1:0];
      end
    end
    if (state_q == isd_pkg::S_RD_J) begin
      val_i_q <= ram_rdata;
    end
    if (finish) begin
      drawn_id_q <= isd_pkg::ValW'(ram_rdata);
    end
  end

  // Entry i takes the old entry j in the cycle after the item finishes; the
  // table port is free then because the next item writes the table only in
  // its later access states, and a load in that cycle is steered around it.
  logic fix_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_pend_q <= 1'b0;
    end else begin
      fix_pend_q <= fix_i;
    end
  end

  logic                fix_we;
  logic [AW-1:0]       ram_waddr_m;
  logic [ID_WIDTH-1:0] ram_wdata_m;
  logic                ram_we_m;
  logic [AW-1:0]       fix_addr_q;
  logic [ID_WIDTH-1:0] fix_data_q;
  logic                held_we_q;
  logic [AW-1:0]       held_addr_q;
  logic [ID_WIDTH-1:0] held_data_q;

  always_ff @(posedge clk_i) begin
    if (fix_i) begin
      fix_addr_q <= AW'(i_q);
      fix_data_q <= ram_rdata;
    end
    held_addr_q <= ram_waddr;
    held_data_q <= ram_wdata;
  end

  // back-to-back loads stay one register behind until the load stream breaks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_we_q <= 1'b0;
    end else begin
      held_we_q <= (fix_pend_q || held_we_q) && ram_we;
    end
  end

  assign fix_we = fix_pend_q;

  always_comb begin
    ram_we_m    = ram_we;
    ram_waddr_m = ram_waddr;
    ram_wdata_m = ram_wdata;
    if (fix_we) begin
      ram_we_m    = 1'b1;
      ram_waddr_m = fix_addr_q;
      ram_wdata_m = fix_data_q;
    end else if (held_we_q) begin
      ram_we_m    = 1'b1;
      ram_waddr_m = held_addr_q;
      ram_wdata_m = held_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drawn_id_o  = drawn_id_q;

  isd_divider #(
    .W(RndW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  isd_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we_m),
    .waddr_i (ram_waddr_m),
    .wdata_i (ram_wdata_m),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != isd_pkg::S_IDLE) |-> (i_q < n_q))
    else $error("draw position not below song count");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == isd_pkg::S_RD_I) |-> (j_q >= i_q && j_q < n_q))
    else $error("pick outside unshuffled tail");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == isd_pkg::S_START2) |-> (div_q != '0))
    else $error("zero divisor for second division");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == isd_pkg::S_DIV1 || state_q == isd_pkg::S_DIV2))
    else $error("divider finished outside a wait state");

endmodule

// ----- rtl/isd_ram.sv -----
// ----------------------------------------------------------------------------
// isd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module isd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/isd_divider.sv -----
// ----------------------------------------------------------------------------
// isd_divider
// Restoring unsigned divider, one quotient bit per cycle. Divisor nonzero.
// ----------------------------------------------------------------------------
module isd_divider #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quotient_o,
  output logic         done_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dsr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- bench/shuffle_draw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffle_draw_checker
// Watches the item, result and song count channels of the shuffle draw block.
// Keeps its own id table, draw position and song count, works out the id that
// each draw deals, and compares every result with the oldest expected id.
// ----------------------------------------------------------------------------
module shuffle_draw_checker #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned RANDOM_MAX  = 2147483647
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      command_i,
  input  logic [isd_pkg::IdxW-1:0]  entry_index_i,
  input  logic [isd_pkg::ValW-1:0]  entry_value_i,
  input  logic [isd_pkg::RndW-1:0]  random_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [isd_pkg::ValW-1:0]  drawn_id_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [isd_pkg::CntW-1:0]  cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  logic [isd_pkg::ValW-1:0] id_shadow [TABLE_DEPTH];
  logic [isd_pkg::CntW-1:0] song_count;
  int unsigned              position;
  logic [isd_pkg::ValW-1:0] expected_ids [$];
  int                       fails = 0;
  int                       waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic int unsigned active_count();
    int unsigned n;
    n = 32'(song_count);
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fails++;
  endtask

  // one incremental Fisher-Yates step over the tail [i, n-1]
  task automatic deal(input logic [isd_pkg::RndW-1:0] r);
    int unsigned              n, i, j, dv, q;
    logic [isd_pkg::ValW-1:0] t;
    n = active_count();
    i = position;
    if (i >= n) i = 0;
    dv = RANDOM_MAX / (n - i);
    if (dv == 0) dv = 1;
    q = 32'(r) / dv;
    j = (q > n - 1 - i) ? n - 1 : i + q;
    t            = id_shadow[j];
    id_shadow[j] = id_shadow[i];
    id_shadow[i] = t;
    expected_ids.push_back(id_shadow[i]);
    position = i + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [isd_pkg::ValW-1:0] want;
    if (!rst_ni) begin
      song_count = 1;
      position   = 0;
      expected_ids.delete();
      waiting <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) song_count = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_ids.size() == 0) begin
          report_mismatch($sformatf("drawn id %h with no draw outstanding", drawn_id_i));
        end else begin
          want = expected_ids.pop_front();
          if (drawn_id_i !== want)
            report_mismatch($sformatf("drawn id %h, expected %h", drawn_id_i, want));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == isd_pkg::CMD_LOAD) id_shadow[entry_index_i] = entry_value_i;
        else deal(random_value_i);
      end
      waiting <= expected_ids.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and draw items into the shuffle draw block over a range of song
// counts, with bursty input, a patterned result stall and one long hold-off,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned               Depth         = 4096;
  localparam logic [isd_pkg::RndW-1:0]  RandMax       = 31'h7FFF_FFFF;
  localparam int unsigned               LimitCycles   = 3_000_000;
  localparam int unsigned               DrainCycles   = 100;
  localparam int unsigned               IdleCycles    = 80;
  localparam int unsigned               HoldCycles    = 500;
  localparam int unsigned               NumPhases     = 14;
  localparam int unsigned               ItemsPerPhase = 112;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      command = isd_pkg::CMD_LOAD;
  logic [isd_pkg::IdxW-1:0]  entry_index = '0;
  logic [isd_pkg::ValW-1:0]  entry_value = '0;
  logic [isd_pkg::RndW-1:0]  random_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [isd_pkg::ValW-1:0]  drawn_id;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [isd_pkg::CntW-1:0]  cfg_data = '0;
  int                        fail_count;
  int                        pending;
  logic                      hold_req = 1'b0;

  bit          loaded [Depth];
  int unsigned active_n = 1;
  int          burst_left = 0;
  bit          offering = 1'b0;

  incremental_shuffle_draw dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .entry_index_i  (entry_index),
    .entry_value_i  (entry_value),
    .random_value_i (random_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .drawn_id_o     (drawn_id),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  shuffle_draw_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .entry_index_i  (entry_index),
    .entry_value_i  (entry_value),
    .random_value_i (random_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .drawn_id_i     (drawn_id),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(LimitCycles * 10);
    $display("run timed out");
    $display("CHECKS FAILED");
    $finish;
  end

  // result stall pattern, with one long hold-off on request
  initial begin : receiver
    int  seg, mode, k;
    bit  held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        for (k = 0; k < HoldCycles; k++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        held = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(10, 300);
        for (k = 0; k < seg; k++) begin
          @(posedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= ($urandom_range(0, 9) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [isd_pkg::RndW-1:0] rand_pick();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RandMax;
      2: return isd_pkg::RndW'(RandMax - $urandom_range(0, 63));
      3: return isd_pkg::RndW'($urandom_range(0, 255));
      default: return isd_pkg::RndW'($urandom_range(0, RandMax));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [isd_pkg::IdxW-1:0] idx,
                           input logic [isd_pkg::ValW-1:0] val,
                           input logic [isd_pkg::RndW-1:0] rnd);
    int gap;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    in_valid     <= 1'b1;
    command      <= cmd;
    entry_index  <= idx;
    entry_value  <= val;
    random_value <= rnd;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        8:       gap = $urandom_range(10, 40);
        9:       gap = $urandom_range(60, 100);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop valid and wait until every dealt id is out and the block is quiet
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= isd_pkg::CntW'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_n = (value == 0) ? 1 : (value > Depth) ? Depth : value;
  endtask

  initial begin : stimulus
    int unsigned              phase_counts [NumPhases];
    int unsigned              p, k;
    logic [isd_pkg::IdxW-1:0] idx;
    phase_counts = '{3, 200, 250, 17, 64, 1, 2, 129, 100, 37, 0, 9, 0, 31};
    phase_counts[10] = $urandom_range(1, 250);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: song count 1 after reset
    send_item(isd_pkg::CMD_LOAD, 0, 32'hFFFF_FFFF, '0);
    send_item(isd_pkg::CMD_LOAD, isd_pkg::IdxW'(Depth - 1), 32'h0000_0000, RandMax);
    loaded[0] = 1'b1;
    loaded[Depth - 1] = 1'b1;
    send_item(isd_pkg::CMD_DRAW, isd_pkg::IdxW'(Depth - 1), 32'hFFFF_FFFF, '0);
    send_item(isd_pkg::CMD_DRAW, 0, '0, RandMax);
    send_item(isd_pkg::CMD_LOAD, 0, 32'h0000_0000, '0);
    send_item(isd_pkg::CMD_DRAW, 0, '0, RandMax);

    write_count(5);
    send_item(isd_pkg::CMD_LOAD, 1, 32'hA5A5_A5A5, '0);
    send_item(isd_pkg::CMD_LOAD, 2, 32'h5A5A_5A5A, '0);
    send_item(isd_pkg::CMD_LOAD, 3, 32'h0F0F_0F0F, '0);
    send_item(isd_pkg::CMD_LOAD, 4, 32'h1234_5678, '0);
    for (k = 1; k < 5; k++) loaded[k] = 1'b1;
    send_item(isd_pkg::CMD_DRAW, 0, '0, '0);
    send_item(isd_pkg::CMD_DRAW, 0, '0, RandMax);
    send_item(isd_pkg::CMD_DRAW, 0, '0, RandMax - 1);
    send_item(isd_pkg::CMD_DRAW, 0, '0, 31'd1);
    send_item(isd_pkg::CMD_DRAW, 0, '0, 31'h4000_0000);
    send_item(isd_pkg::CMD_DRAW, 0, '0, RandMax);
    send_item(isd_pkg::CMD_DRAW, 0, '0, '0);

    // position now 3: lowering the count forces a wrap
    write_count(2);
    send_item(isd_pkg::CMD_DRAW, 0, '0, 31'h2AAA_AAAA);
    write_count(0);
    send_item(isd_pkg::CMD_DRAW, 0, '0, RandMax);

    for (p = 0; p < NumPhases; p++) begin
      write_count(phase_counts[p]);
      for (k = 0; k < active_n; k++) begin
        if (!loaded[k]) begin
          loaded[k] = 1'b1;
          send_item(isd_pkg::CMD_LOAD, isd_pkg::IdxW'(k), $urandom, rand_pick());
        end
      end
      if (p == 3) hold_req <= 1'b1;
      for (k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          idx = ($urandom_range(0, 4) == 0) ? isd_pkg::IdxW'($urandom_range(0, Depth - 1))
                                            : isd_pkg::IdxW'($urandom_range(0, active_n - 1));
          loaded[idx] = 1'b1;
          send_item(isd_pkg::CMD_LOAD, idx, $urandom, rand_pick());
        end else begin
          send_item(isd_pkg::CMD_DRAW, isd_pkg::IdxW'($urandom_range(0, Depth - 1)),
                    $urandom, rand_pick());
        end
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/isd_pkg.sv
rtl/isd_ram.sv
rtl/isd_divider.sv
rtl/incremental_shuffle_draw.sv
bench/shuffle_draw_checker.sv
bench/tb_top.sv
